@@ hw/rtl/fpsm_pkg.sv @@
// shared types, constants and helpers of the five-point stencil block
`default_nettype none

package fpsm_pkg;

  // number format and grid limits
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;
  localparam int SIZE_W    = 11;
  localparam int POS_W     = 10;
  localparam int COL_AW    = $clog2(MAX_COLS);

  // stencil taps
  localparam int NTAPS      = 5;
  localparam int TAP_CENTER = 0;
  localparam int TAP_NORTH  = 1;
  localparam int TAP_SOUTH  = 2;
  localparam int TAP_WEST   = 3;
  localparam int TAP_EAST   = 4;

  // job queue between front and back
  localparam int MAX_JOBS = 3;
  localparam int JCNT_W   = $clog2(MAX_JOBS + 1);
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = QPTR_W + 1;
  localparam int Q_ROOM   = QDEPTH - 2 * MAX_JOBS;

  // arithmetic widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_t;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t x_value;
    word_t coef_center;
    word_t coef_north;
    word_t coef_south;
    word_t coef_west;
    word_t coef_east;
  } in_item_t;

  typedef struct packed {
    word_t              y_value;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic               grid_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] wr_index;
    logic [SIZE_W-1:0]    wr_data;
  } cfg_item_t;

  // one result to compute: masked coefficients and matching x values
  typedef struct packed {
    logic [NTAPS-1:0][DATA_W-1:0] coef;
    logic [NTAPS-1:0][DATA_W-1:0] xv;
    logic [POS_W-1:0]             row;
    logic [POS_W-1:0]             col;
    logic                         done;
  } job_t;

  // up to three jobs produced by one input point, packed from slot 0
  typedef struct packed {
    logic [JCNT_W-1:0]         n;
    job_t [MAX_JOBS-1:0]       job;
  } job_bundle_t;

  // a size of zero counts as one, a size above the limit as the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fpsm_if.sv @@
// handshake channel interfaces of the stencil block
`default_nettype none

interface fpsm_in_if import fpsm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpsm_out_if import fpsm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpsm_cfg_if import fpsm_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fpsm_ram.sv @@
// generic single-write, single-read memory with registered read data
`default_nettype none

module fpsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fpsm_front.sv @@
// front end: grid position, line stores and job building per input point
`default_nettype none

module fpsm_front import fpsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fpsm_in_if.sink                in_if,
  fpsm_cfg_if.sink               cfg_if,
  input  wire logic [QCNT_W-1:0] q_count,
  output job_bundle_t            bundle_o
);

  logic [SIZE_W-1:0] rows_r, cols_r, rows_eff, cols_eff;
  logic [POS_W-1:0]  row_r, col_r, row_nxt, col_nxt;
  logic              last_row, last_col, acc, cfg_wr;
  logic [COL_AW-1:0] col_addr, col_plus;
  logic [NTAPS-1:0][DATA_W-1:0] coef_in, coef_line;
  word_t             xa_rd, xe_rd, x2_rd, x2_val;

  // stage 1 registers
  logic              s1_valid_r;
  logic [POS_W-1:0]  s1_row_r, s1_col_r;
  word_t             s1_x_r;
  logic [NTAPS-1:0][DATA_W-1:0] s1_coef_r;
  logic              s1_last_row_r, s1_last_col_r;
  logic              fwd_hit_r, fwd_hit_nxt;
  word_t             fwd_data_r;

  // values of the point before
  word_t             prev_x_r, pprev_x_r, prev_north_r;
  logic [NTAPS-1:0][DATA_W-1:0] prev_coef_r;

  job_t              cand [MAX_JOBS];
  logic [MAX_JOBS-1:0] cand_v;

  // effective sizes and handshakes
  assign rows_eff     = clamp_size(rows_r, SIZE_W'(MAX_ROWS));
  assign cols_eff     = clamp_size(cols_r, SIZE_W'(MAX_COLS));
  assign in_if.ready  = (q_count <= QCNT_W'(Q_ROOM));
  assign cfg_if.ready = 1'b1;
  assign acc          = in_if.valid && in_if.ready;
  assign cfg_wr       = cfg_if.valid;

  // position stepping in raster order
  always_comb begin
    last_row = ({1'b0, row_r} == rows_eff - SIZE_W'(1));
    last_col = ({1'b0, col_r} == cols_eff - SIZE_W'(1));
    col_nxt  = last_col ? '0 : col_r + POS_W'(1);
    row_nxt  = row_r;
    if (last_col) begin
      row_nxt = last_row ? '0 : row_r + POS_W'(1);
    end
  end

  // configuration registers and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(1);
      cols_r <= SIZE_W'(1);
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_if.data.wr_index))
        REG_GRID_ROWS: begin
          rows_r <= cfg_if.data.wr_data;
          row_r  <= '0;
          col_r  <= '0;
        end
        REG_GRID_COLS: begin
          cols_r <= cfg_if.data.wr_data;
          row_r  <= '0;
          col_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line stores, all indexed by column
  assign col_addr = col_r[COL_AW-1:0];
  assign col_plus = col_addr + COL_AW'(1);

  always_comb begin
    coef_in             = '0;
    coef_in[TAP_CENTER] = in_if.data.coef_center;
    coef_in[TAP_NORTH]  = in_if.data.coef_north;
    coef_in[TAP_SOUTH]  = in_if.data.coef_south;
    coef_in[TAP_WEST]   = in_if.data.coef_west;
    coef_in[TAP_EAST]   = in_if.data.coef_east;
  end

  fpsm_ram #(.WIDTH(NTAPS*DATA_W), .DEPTH(MAX_COLS)) u_coef_ram (
    .clk(clk), .we(acc), .waddr(col_addr), .wdata(coef_in),
    .re(acc), .raddr(col_addr), .rdata(coef_line)
  );

  // previous row x, read at this column
  fpsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_xa_ram (
    .clk(clk), .we(acc), .waddr(col_addr), .wdata(in_if.data.x_value),
    .re(acc), .raddr(col_addr), .rdata(xa_rd)
  );

  // previous row x, read one column ahead
  fpsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_xe_ram (
    .clk(clk), .we(acc), .waddr(col_addr), .wdata(in_if.data.x_value),
    .re(acc), .raddr(col_plus), .rdata(xe_rd)
  );

  // x two rows back, filled from stage 1
  fpsm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_x2_ram (
    .clk(clk), .we(s1_valid_r), .waddr(s1_col_r[COL_AW-1:0]), .wdata(xa_rd),
    .re(acc), .raddr(col_addr), .rdata(x2_rd)
  );

  // single-column grids write and read the same entry in the same cycle
  assign fwd_hit_nxt = s1_valid_r && (s1_col_r == col_r);
  assign x2_val      = fwd_hit_r ? fwd_data_r : x2_rd;

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_x_r        <= in_if.data.x_value;
      s1_coef_r     <= coef_in;
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
      fwd_hit_r     <= fwd_hit_nxt;
      fwd_data_r    <= xa_rd;
    end
    if (s1_valid_r) begin
      prev_x_r     <= s1_x_r;
      pprev_x_r    <= prev_x_r;
      prev_north_r <= xa_rd;
      prev_coef_r  <= s1_coef_r;
    end
  end

  // build the jobs of the point in stage 1, absent neighbors zeroed
  always_comb begin
    logic r_gt0, r_ge2, c_gt0, c_ge2;
    r_gt0 = (s1_row_r != '0);
    r_ge2 = (s1_row_r > POS_W'(1));
    c_gt0 = (s1_col_r != '0);
    c_ge2 = (s1_col_r > POS_W'(1));

    // point one row up, now that its south neighbor is here
    cand[0]                 = '0;
    cand[0].row             = s1_row_r - POS_W'(1);
    cand[0].col             = s1_col_r;
    cand[0].coef[TAP_CENTER] = coef_line[TAP_CENTER];
    cand[0].coef[TAP_NORTH] = r_ge2 ? coef_line[TAP_NORTH] : '0;
    cand[0].coef[TAP_SOUTH] = coef_line[TAP_SOUTH];
    cand[0].coef[TAP_WEST]  = c_gt0 ? coef_line[TAP_WEST] : '0;
    cand[0].coef[TAP_EAST]  = s1_last_col_r ? '0 : coef_line[TAP_EAST];
    cand[0].xv[TAP_CENTER]  = xa_rd;
    cand[0].xv[TAP_NORTH]   = r_ge2 ? x2_val : '0;
    cand[0].xv[TAP_SOUTH]   = s1_x_r;
    cand[0].xv[TAP_WEST]    = c_gt0 ? prev_north_r : '0;
    cand[0].xv[TAP_EAST]    = s1_last_col_r ? '0 : xe_rd;

    // last row: the point to the left, now that its east neighbor is here
    cand[1]                 = '0;
    cand[1].row             = s1_row_r;
    cand[1].col             = s1_col_r - POS_W'(1);
    cand[1].coef[TAP_CENTER] = prev_coef_r[TAP_CENTER];
    cand[1].coef[TAP_NORTH] = r_gt0 ? prev_coef_r[TAP_NORTH] : '0;
    cand[1].coef[TAP_WEST]  = c_ge2 ? prev_coef_r[TAP_WEST] : '0;
    cand[1].coef[TAP_EAST]  = prev_coef_r[TAP_EAST];
    cand[1].xv[TAP_CENTER]  = prev_x_r;
    cand[1].xv[TAP_NORTH]   = r_gt0 ? prev_north_r : '0;
    cand[1].xv[TAP_WEST]    = c_ge2 ? pprev_x_r : '0;
    cand[1].xv[TAP_EAST]    = s1_x_r;

    // last point of the grid itself
    cand[2]                 = '0;
    cand[2].row             = s1_row_r;
    cand[2].col             = s1_col_r;
    cand[2].done            = 1'b1;
    cand[2].coef[TAP_CENTER] = s1_coef_r[TAP_CENTER];
    cand[2].coef[TAP_NORTH] = r_gt0 ? s1_coef_r[TAP_NORTH] : '0;
    cand[2].coef[TAP_WEST]  = c_gt0 ? s1_coef_r[TAP_WEST] : '0;
    cand[2].xv[TAP_CENTER]  = s1_x_r;
    cand[2].xv[TAP_NORTH]   = r_gt0 ? xa_rd : '0;
    cand[2].xv[TAP_WEST]    = c_gt0 ? prev_x_r : '0;

    cand_v[0] = s1_valid_r && r_gt0;
    cand_v[1] = s1_valid_r && s1_last_row_r && c_gt0;
    cand_v[2] = s1_valid_r && s1_last_row_r && s1_last_col_r;

    // pack the valid jobs from slot 0 in result order
    bundle_o        = '0;
    bundle_o.n      = JCNT_W'(cand_v[0]) + JCNT_W'(cand_v[1]) + JCNT_W'(cand_v[2]);
    bundle_o.job[0] = cand_v[0] ? cand[0] : (cand_v[1] ? cand[1] : cand[2]);
    bundle_o.job[1] = (cand_v[0] && cand_v[1]) ? cand[1] : cand[2];
    bundle_o.job[2] = cand[2];
  end

  // same-entry forwarding only arises on single-column grids
  a_fwd_single_col: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && fwd_hit_nxt) |-> (cols_eff == SIZE_W'(1)))
    else $error("x forwarding hit with more than one column");

endmodule

`default_nettype wire

@@ hw/rtl/fpsm_queue.sv @@
// short job queue: up to three pushes and one pop per cycle
`default_nettype none

module fpsm_queue import fpsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire job_bundle_t       push_i,
  input  wire logic              pop_i,
  output job_t                   head_o,
  output logic                   head_valid_o,
  output logic [QCNT_W-1:0]      count_o
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign count_nxt    = count_r + QCNT_W'(push_i.n) - QCNT_W'(pop_i);
  assign head_o       = q_r[rd_ptr_r];
  assign head_valid_o = (count_r != '0);
  assign count_o      = count_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_i.n);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop_i);
      count_r  <= count_nxt;
    end
  end

  // storage, consecutive slots from the write pointer
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_JOBS; k++) begin
      if (JCNT_W'(k) < push_i.n) begin
        q_r[wr_ptr_r + QPTR_W'(k)] <= push_i.job[k];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((QCNT_W+1)'(count_r) + (QCNT_W+1)'(push_i.n) <= (QCNT_W+1)'(QDEPTH)))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("job queue pop while empty");

endmodule

`default_nettype wire

@@ hw/rtl/fpsm_back.sv @@
// back end: five multiplies, exact sum, floor shift and saturation
`default_nettype none

module fpsm_back import fpsm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire job_t  head_i,
  input  wire logic  head_valid_i,
  output logic       pop_o,
  fpsm_out_if.source out_if
);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } res_tag_t;

  logic en;
  logic b1_v_r, b2_v_r, b3_v_r, out_valid_r;
  res_tag_t b1_tag_r, b2_tag_r, b3_tag_r;
  logic signed [PROD_W-1:0] b1_prod_r [NTAPS];
  logic signed [PROD_W-1:0] prod_nxt [NTAPS];
  logic signed [SUM_W-1:0]  ext [NTAPS];
  logic signed [SUM_W-1:0]  b2_a_r, b2_b_r, b2_c_r, b3_sum_r;
  logic [SUM_W-1:FRAC_BITS+DATA_W-1] sum_hi;
  out_item_t out_data_r, out_nxt;

  // the whole pipe moves when the output register is free or taken
  assign en           = !out_valid_r || out_if.ready;
  assign pop_o        = en && head_valid_i;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // products of each tap
  always_comb begin
    for (int k = 0; k < NTAPS; k++) begin
      prod_nxt[k] = $signed(head_i.coef[k]) * $signed(head_i.xv[k]);
      ext[k]      = {{(SUM_W-PROD_W){b1_prod_r[k][PROD_W-1]}}, b1_prod_r[k]};
    end
  end

  // floor shift and saturate to the word range
  always_comb begin
    sum_hi            = b3_sum_r[SUM_W-1:FRAC_BITS+DATA_W-1];
    out_nxt.out_row   = b3_tag_r.row;
    out_nxt.out_col   = b3_tag_r.col;
    out_nxt.grid_done = b3_tag_r.done;
    if ((&sum_hi) || !(|sum_hi)) begin
      out_nxt.y_value = b3_sum_r[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end else begin
      out_nxt.y_value = b3_sum_r[SUM_W-1] ? WORD_MIN : WORD_MAX;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_v_r      <= head_valid_i;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      out_valid_r <= b3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NTAPS; k++) begin
        b1_prod_r[k] <= prod_nxt[k];
      end
      b1_tag_r   <= '{row: head_i.row, col: head_i.col, done: head_i.done};
      b2_a_r     <= ext[TAP_CENTER] + ext[TAP_NORTH];
      b2_b_r     <= ext[TAP_SOUTH] + ext[TAP_WEST];
      b2_c_r     <= ext[TAP_EAST];
      b2_tag_r   <= b1_tag_r;
      b3_sum_r   <= b2_a_r + b2_b_r + b2_c_r;
      b3_tag_r   <= b2_tag_r;
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/five_point_stencil_matvec.sv @@
// top level of the five-point stencil matrix-vector product block
//
// Grid points enter on in_if in row-major order, one per transfer, each with
// its Q16.16 x value and five coefficients. Results leave on out_if with the
// saturated Q16.16 product, their row and column, and grid_done set on the
// final result of the grid. Grid size is written on cfg_if (index 0 rows,
// index 1 columns); a write restarts the grid at row 0, column 0, and must
// happen only while the block is idle. cfg_if.ready is always high.
// Throughput is one point and one result per cycle while out_if takes results
// and the job queue has room. A point of row r releases the result of row
// r-1 in the same column, so results trail their points by one grid row;
// points of the last row also release the point to their left, and the last
// point releases itself. Pipeline: each point is registered with its memory
// reads in stage 1, where its jobs are built and queued; each result then
// passes the multiply, two add stages and the output register. The last row
// makes up to three results per point; an 8-entry job queue absorbs them and
// in_if.ready drops while it holds more than two jobs. When out_if stalls,
// the back end holds and the queue fills, then in_if stalls. Reset empties
// the pipe and sets the grid to 1 x 1; the line stores need no clearing.
`default_nettype none

module five_point_stencil_matvec import fpsm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpsm_in_if.sink    in_if,
  fpsm_out_if.source out_if,
  fpsm_cfg_if.sink   cfg_if
);

  job_bundle_t       bundle;
  job_t              head;
  logic              head_valid, pop;
  logic [QCNT_W-1:0] q_count;

  fpsm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .cfg_if(cfg_if),
    .q_count(q_count), .bundle_o(bundle)
  );

  fpsm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_i(bundle), .pop_i(pop),
    .head_o(head), .head_valid_o(head_valid), .count_o(q_count)
  );

  fpsm_back u_back (
    .clk(clk), .rst_n(rst_n), .head_i(head), .head_valid_i(head_valid),
    .pop_o(pop), .out_if(out_if)
  );

endmodule

`default_nettype wire

@@ tb/fpsm_checker.sv @@
// checker for the stencil block: predicts results from observed transfers and compares
`default_nettype none

module fpsm_checker import fpsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fpsm_in_if.sink   in_mon,
  fpsm_out_if.sink  out_mon,
  fpsm_cfg_if.sink  cfg_mon,
  output int        fail_count,
  output int        pending
);

  // predictor state
  word_t x_store [2][MAX_COLS];
  word_t c_store [5][MAX_COLS];
  int unsigned cur_row, cur_col;
  logic [SIZE_W-1:0] rows_reg, cols_reg;
  out_item_t expected_results [$];

  assign pending = expected_results.size();

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // x at (r,c); the arriving point is not yet stored
  function automatic longint x_at(int unsigned r, int unsigned c, int unsigned pr,
                                  int unsigned pc, word_t px);
    if (r == pr && c == pc) return longint'($signed(px));
    return longint'($signed(x_store[r & 1][c]));
  endfunction

  // stencil product for point (r,c) with floor shift and saturation
  function automatic out_item_t stencil_result(int unsigned r, int unsigned c,
      int unsigned nr, int unsigned nc, int unsigned pr, int unsigned pc, word_t px,
      logic last);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] sh;
    out_item_t o;
    acc = $signed(c_store[TAP_CENTER][c]) * x_at(r, c, pr, pc, px);
    if (r > 0) acc += $signed(c_store[TAP_NORTH][c]) * x_at(r - 1, c, pr, pc, px);
    if (r + 1 < nr) acc += $signed(c_store[TAP_SOUTH][c]) * x_at(r + 1, c, pr, pc, px);
    if (c > 0) acc += $signed(c_store[TAP_WEST][c]) * x_at(r, c - 1, pr, pc, px);
    if (c + 1 < nc) acc += $signed(c_store[TAP_EAST][c]) * x_at(r, c + 1, pr, pc, px);
    sh = acc >>> FRAC_BITS;
    if (sh > $signed({{(SUM_W-DATA_W){1'b0}}, WORD_MAX})) o.y_value = WORD_MAX;
    else if (sh < -$signed({{(SUM_W-DATA_W){1'b0}}, WORD_MIN})) o.y_value = WORD_MIN;
    else o.y_value = sh[DATA_W-1:0];
    o.out_row = r[POS_W-1:0];
    o.out_col = c[POS_W-1:0];
    o.grid_done = last;
    return o;
  endfunction

  task automatic report_mismatch(string what, out_item_t got, out_item_t want);
    $display("mismatch %s: got y=%h r=%0d c=%0d d=%0b want y=%h r=%0d c=%0d d=%0b",
             what, got.y_value, got.out_row, got.out_col, got.grid_done,
             want.y_value, want.out_row, want.out_col, want.grid_done);
    fail_count++;
  endtask

  // predict on each point transfer
  task automatic accept_point(in_item_t p);
    int unsigned nr, nc, r, c;
    nr = eff_size(rows_reg, MAX_ROWS);
    nc = eff_size(cols_reg, MAX_COLS);
    r = cur_row;
    c = cur_col;
    if (r >= nr || c >= nc) begin
      r = 0;
      c = 0;
    end
    if (r > 0) expected_results.push_back(stencil_result(r - 1, c, nr, nc, r, c, p.x_value, 0));
    c_store[TAP_CENTER][c] = p.coef_center;
    c_store[TAP_NORTH][c] = p.coef_north;
    c_store[TAP_SOUTH][c] = p.coef_south;
    c_store[TAP_WEST][c] = p.coef_west;
    c_store[TAP_EAST][c] = p.coef_east;
    if (r + 1 == nr) begin
      if (c > 0) expected_results.push_back(stencil_result(r, c - 1, nr, nc, r, c, p.x_value, 0));
      if (c + 1 == nc) expected_results.push_back(stencil_result(r, c, nr, nc, r, c, p.x_value, 1));
    end
    x_store[r & 1][c] = p.x_value;
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  // watch all channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rows_reg <= 1;
      cols_reg <= 1;
      cur_row = 0;
      cur_col = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data.wr_index == REG_GRID_ROWS) rows_reg <= cfg_mon.data.wr_data;
        else if (cfg_mon.data.wr_index == REG_GRID_COLS) cols_reg <= cfg_mon.data.wr_data;
        cur_row = 0;
        cur_col = 0;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          want = '0;
          report_mismatch("unexpected", out_mon.data, want);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.data.y_value !== want.y_value) report_mismatch("y_value", out_mon.data, want);
          if (out_mon.data.out_row !== want.out_row) report_mismatch("out_row", out_mon.data, want);
          if (out_mon.data.out_col !== want.out_col) report_mismatch("out_col", out_mon.data, want);
          if (out_mon.data.grid_done !== want.grid_done)
            report_mismatch("grid_done", out_mon.data, want);
        end
      end
      if (in_mon.valid && in_mon.ready) accept_point(in_mon.data);
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_five_point_stencil_matvec.sv @@
// testbench top: stimulus, idling control and verdict for the stencil block
`default_nettype none

module tb_five_point_stencil_matvec;
  import fpsm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int fail_count, pending;
  int cycle_count = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  localparam int CYCLE_LIMIT = 400000;

  fpsm_in_if in_ch();
  fpsm_out_if out_ch();
  fpsm_cfg_if cfg_ch();

  five_point_stencil_matvec uut (.clk(clk), .rst_n(rst_n), .in_if(in_ch.sink),
                                 .out_if(out_ch.source), .cfg_if(cfg_ch.sink));

  fpsm_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_five_point_stencil_matvec: errors");
      $finish;
    end
  end

  // receiver: random stalls plus the long hold-off
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom_range(3)) - 1;
      3: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  // one point transfer, with random sender idling; valid stays up afterwards
  task automatic send_point(in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    in_item_t p;
    repeat (n) begin
      p = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      send_point(p);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [SIZE_W-1:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data <= '{wr_index: idx, wr_data: v};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] nr, logic [SIZE_W-1:0] nc);
    drain();
    write_reg(REG_GRID_ROWS, nr);
    write_reg(REG_GRID_COLS, nc);
    cfg_ch.valid <= 0;
  endtask

  initial begin
    in_item_t p;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: 1x1 default grid with extreme values
    p = {WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX};
    send_point(p);
    p = {WORD_MIN, WORD_MIN, word_t'(0), word_t'(0), word_t'(0), word_t'(0)};
    send_point(p);
    // 3x3 grid, saturation both ways and all-ones bits
    set_grid(SIZE_W'(3), SIZE_W'(3));
    for (int i = 0; i < 9; i++) begin
      if (i[0]) p = {WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
      else p = {WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
      send_point(p);
    end
    // zero sizes count as one; a single row and a single column
    set_grid(SIZE_W'(0), SIZE_W'(0));
    send_random(2);
    set_grid(SIZE_W'(1), SIZE_W'(4));
    send_random(4);
    set_grid(SIZE_W'(5), SIZE_W'(1));
    send_random(5);

    // phase one: sender idles a little, receiver a lot
    send_idle_pct = 21;
    recv_idle_pct = 57;
    set_grid(SIZE_W'(4), SIZE_W'(5));
    send_random(40);
    set_grid(SIZE_W'(2), SIZE_W'(3));
    send_random(9);  // partial grid, then restart on write
    set_grid(SIZE_W'(6), SIZE_W'(7));
    send_random(42);

    // pressure: long receiver hold-off while points keep coming
    send_idle_pct = 0;
    hold_off = 1;
    fork
      send_random(35);
      begin
        repeat (120) @(negedge clk);
        hold_off = 0;
      end
    join

    // phase two: roles swapped
    send_idle_pct = 57;
    recv_idle_pct = 21;
    set_grid(SIZE_W'(3), SIZE_W'(11));
    send_random(66);
    // maximum width row with overflow size clamps to the limit
    set_grid(SIZE_W'(1), 11'd1025);
    send_random(30);

    // phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(SIZE_W'(2), SIZE_W'(2));
    send_random(24);
    set_grid(11'd1024, SIZE_W'(2));
    send_random(20);
    set_grid(SIZE_W'(8), SIZE_W'(4));
    send_random(32);

    drain();
    if (fail_count == 0) begin
      $display("tb_five_point_stencil_matvec: clean");
    end else begin
      $display("tb_five_point_stencil_matvec: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
